### rtl/core/clock_offset_pi_discipline_unit_defines.svh
// ----------------------------------------------------------------------------
// Clock offset PI discipline: assertion macros
// Shared assertion forms; the using module provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef CLOCK_OFFSET_PI_DISCIPLINE_UNIT_DEFINES_SVH
`define CLOCK_OFFSET_PI_DISCIPLINE_UNIT_DEFINES_SVH

// same-cycle implication
`define COPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("copd assertion failed");

// next-cycle implication
`define COPD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("copd assertion failed");

`endif

### rtl/core/copd_pkg.sv
// ----------------------------------------------------------------------------
// Clock offset PI discipline package
// Shared types, register indexes and datapath command codes.
// ----------------------------------------------------------------------------
package copd_pkg;

	localparam int unsigned MAX_INTERVAL = 16;

	// register indexes
	localparam logic [2:0] CFG_STEP_LIMIT    = 3'd0;
	localparam logic [2:0] CFG_STATS_ALPHA   = 3'd1;
	localparam logic [2:0] CFG_GAIN_PER_RMS  = 3'd2;
	localparam logic [2:0] CFG_GAIN_MAX      = 3'd3;
	localparam logic [2:0] CFG_GAIN_MIN      = 3'd4;
	localparam logic [2:0] CFG_INTEGRAL_RATE = 3'd5;
	localparam logic [2:0] CFG_TRIM_LIMIT    = 3'd6;

	// datapath operations
	localparam logic [4:0] OP_NONE   = 5'd0;
	localparam logic [4:0] OP_PREP   = 5'd1;
	localparam logic [4:0] OP_STEP   = 5'd2;
	localparam logic [4:0] OP_CAP_X2 = 5'd3;
	localparam logic [4:0] OP_CAP_D2 = 5'd4;
	localparam logic [4:0] OP_DIFF   = 5'd5;
	localparam logic [4:0] OP_VHI    = 5'd6;
	localparam logic [4:0] OP_VLO    = 5'd7;
	localparam logic [4:0] OP_MHI    = 5'd8;
	localparam logic [4:0] OP_MLO    = 5'd9;
	localparam logic [4:0] OP_MEAN   = 5'd10;
	localparam logic [4:0] OP_INIT   = 5'd11;
	localparam logic [4:0] OP_DEV    = 5'd12;
	localparam logic [4:0] OP_RMS    = 5'd13;
	localparam logic [4:0] OP_GAIN   = 5'd14;
	localparam logic [4:0] OP_PROP   = 5'd15;
	localparam logic [4:0] OP_INT    = 5'd16;
	localparam logic [4:0] OP_TRIM   = 5'd17;

	// multiplier operand selects
	localparam logic [3:0] MS_X2   = 4'd0;
	localparam logic [3:0] MS_D2   = 4'd1;
	localparam logic [3:0] MS_VHI  = 4'd2;
	localparam logic [3:0] MS_VLO  = 4'd3;
	localparam logic [3:0] MS_MHI  = 4'd4;
	localparam logic [3:0] MS_MLO  = 4'd5;
	localparam logic [3:0] MS_MEAN = 4'd6;
	localparam logic [3:0] MS_GAIN = 4'd7;
	localparam logic [3:0] MS_PROP = 4'd8;
	localparam logic [3:0] MS_INT  = 4'd9;

	typedef struct packed {
		logic [30:0] step_limit;
		logic [15:0] stats_alpha;
		logic [31:0] gain_per_rms;
		logic [15:0] gain_max;
		logic [15:0] gain_min;
		logic [15:0] integral_rate;
		logic [30:0] trim_limit;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic [4:0] op;
		logic [3:0] mul_sel;
		logic       sq_start;
		logic       sq_sel;
		logic       publish;
	} cmd_t;

	typedef struct packed {
		logic step;
		logic init;
		logic sq_done;
		logic sq_busy;
		logic out_free;
	} sts_t;

endpackage

### rtl/core/copd_sqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Bit-serial root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module copd_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        busy,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] rem_q;
	logic [63:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] bit_w;
	logic [63:0] trial;

	assign bit_w = 64'd1 << (6'd62 - {cnt_q, 1'b0});
	assign trial = root_q + bit_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= value;
			root_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_w;
			end else begin
				root_q <= root_q >> 1;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q[31:0];

endmodule

### rtl/core/copd_dpath.sv
// ----------------------------------------------------------------------------
// Clock offset PI discipline datapath
// Loop state, shared multiplier, root unit and the output word register.
// ----------------------------------------------------------------------------
module copd_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  copd_pkg::cfg_t       cfg,
	input  copd_pkg::cmd_t       cmd,
	output copd_pkg::sts_t       sts,
	input  logic [4:0]           poll_interval,
	input  logic signed [63:0]   offset,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 step_clock,
	output logic signed [63:0]   step_amount,
	output logic signed [31:0]   trim_word,
	output logic signed [31:0]   mean_offset,
	output logic [30:0]          rms_offset,
	output logic [30:0]          dev_offset,
	output logic signed [31:0]   prop_term,
	output logic signed [31:0]   integral_term
);

	localparam logic [4:0] IVAL_MAX = 5'(copd_pkg::MAX_INTERVAL);

	// loop state
	logic signed [31:0] mean_q;
	logic [63:0]        var_q;
	logic [63:0]        msq_q;
	logic signed [31:0] integ_q;

	// working registers
	logic signed [63:0] off_q;
	logic [4:0]         ival_q;
	logic signed [31:0] x_q;
	logic [31:0]        ax_q;
	logic               xneg_q;
	logic [31:0]        ad_q;
	logic               dneg_q;
	logic [63:0]        x2_q;
	logic [63:0]        d2_q;
	logic [63:0]        vdiff_q;
	logic               vneg_q;
	logic [63:0]        mdiff_q;
	logic               mneg_q;
	logic [63:0]        acc_q;
	logic [63:0]        mul_q;
	logic [30:0]        rms_q;
	logic [30:0]        dev_q;
	logic [15:0]        gain_q;
	logic [31:0]        pmag_q;
	logic signed [31:0] prop_q;
	logic signed [31:0] trim_q;
	logic               step_q;

	// output word
	logic               ovalid_q;
	logic               ostep_q;
	logic signed [63:0] oamount_q;
	logic signed [31:0] otrim_q;
	logic signed [31:0] omean_q;
	logic [30:0]        orms_q;
	logic [30:0]        odev_q;
	logic signed [31:0] oprop_q;
	logic signed [31:0] ointeg_q;

	logic [31:0]        ma;
	logic [31:0]        mb;
	logic [31:0]        lo_in;
	logic signed [63:0] lim_p;
	logic signed [63:0] lim_n;
	logic signed [32:0] dd;
	logic [63:0]        wfull;
	logic [46:0]        g_raw;
	logic [15:0]        g_hi;
	logic [47:0]        p_shift;
	logic [31:0]        w32;
	logic signed [33:0] iv;
	logic signed [33:0] tv;
	logic signed [33:0] tl_p;
	logic signed [33:0] tl_n;
	logic signed [33:0] iclamp;
	logic signed [33:0] tclamp;
	logic [31:0]        sq_root;
	logic [30:0]        sq_sat;
	logic               sq_busy;
	logic               sq_done;

	copd_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sq_start),
		.value  (cmd.sq_sel ? msq_q : var_q),
		.busy   (sq_busy),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign sq_sat = sq_root[31] ? 31'h7FFF_FFFF : sq_root[30:0];

	assign lo_in = offset[31:0];
	assign lim_p = $signed({33'd0, cfg.step_limit});
	assign lim_n = -lim_p;
	assign dd    = $signed({x_q[31], x_q}) - $signed({mean_q[31], mean_q});
	assign wfull = acc_q + {16'd0, mul_q[63:16]};
	assign g_raw = mul_q[62:16];
	assign g_hi  = (g_raw > {31'd0, cfg.gain_max}) ? cfg.gain_max : g_raw[15:0];
	assign p_shift = mul_q[47:0] >> (6'd16 + {1'b0, ival_q});
	assign w32   = mul_q[47:16];
	assign tl_p  = $signed({3'd0, cfg.trim_limit});
	assign tl_n  = -tl_p;
	assign iv    = xneg_q ? ($signed({{2{integ_q[31]}}, integ_q}) - $signed({2'd0, w32}))
	                      : ($signed({{2{integ_q[31]}}, integ_q}) + $signed({2'd0, w32}));
	assign iclamp = (iv > tl_p) ? tl_p : ((iv < tl_n) ? tl_n : iv);
	assign tv    = $signed({{2{prop_q[31]}}, prop_q}) + $signed({{2{integ_q[31]}}, integ_q});
	assign tclamp = (tv > tl_p) ? tl_p : ((tv < tl_n) ? tl_n : tv);

	always_comb begin
		case (cmd.mul_sel)
			copd_pkg::MS_X2: begin
				ma = ax_q;
				mb = ax_q;
			end
			copd_pkg::MS_D2: begin
				ma = ad_q;
				mb = ad_q;
			end
			copd_pkg::MS_VHI: begin
				ma = vdiff_q[63:32];
				mb = {16'd0, cfg.stats_alpha};
			end
			copd_pkg::MS_VLO: begin
				ma = vdiff_q[31:0];
				mb = {16'd0, cfg.stats_alpha};
			end
			copd_pkg::MS_MHI: begin
				ma = mdiff_q[63:32];
				mb = {16'd0, cfg.stats_alpha};
			end
			copd_pkg::MS_MLO: begin
				ma = mdiff_q[31:0];
				mb = {16'd0, cfg.stats_alpha};
			end
			copd_pkg::MS_MEAN: begin
				ma = ad_q;
				mb = {16'd0, cfg.stats_alpha};
			end
			copd_pkg::MS_GAIN: begin
				ma = {1'b0, rms_q};
				mb = cfg.gain_per_rms;
			end
			copd_pkg::MS_PROP: begin
				ma = ax_q;
				mb = {16'd0, gain_q};
			end
			copd_pkg::MS_INT: begin
				ma = pmag_q;
				mb = {16'd0, cfg.integral_rate};
			end
			default: begin
				ma = ax_q;
				mb = ax_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= {32'd0, ma} * {32'd0, mb};
	end

	// loop state, reset to the uninitialized statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= '0;
			var_q   <= '0;
			msq_q   <= '0;
			integ_q <= '0;
		end else begin
			case (cmd.op)
				copd_pkg::OP_STEP: msq_q <= '0;
				copd_pkg::OP_VLO:  var_q <= vneg_q ? (var_q - wfull) : (var_q + wfull);
				copd_pkg::OP_MLO:  msq_q <= mneg_q ? (msq_q - wfull) : (msq_q + wfull);
				copd_pkg::OP_MEAN: mean_q <= dneg_q ? (mean_q - $signed(w32))
				                                    : (mean_q + $signed(w32));
				copd_pkg::OP_INIT: begin
					mean_q <= x_q;
					var_q  <= x2_q;
					msq_q  <= x2_q;
				end
				copd_pkg::OP_INT:  integ_q <= iclamp[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			off_q  <= offset;
			ival_q <= (poll_interval > IVAL_MAX) ? IVAL_MAX : poll_interval;
			x_q    <= $signed(lo_in);
			ax_q   <= lo_in[31] ? (~lo_in + 32'd1) : lo_in;
			xneg_q <= lo_in[31];
		end
		case (cmd.op)
			copd_pkg::OP_PREP: begin
				dneg_q <= dd[32];
				ad_q   <= dd[32] ? 32'(-dd) : dd[31:0];
			end
			copd_pkg::OP_STEP:   step_q <= 1'b1;
			copd_pkg::OP_CAP_X2: x2_q <= mul_q;
			copd_pkg::OP_CAP_D2: d2_q <= mul_q;
			copd_pkg::OP_DIFF: begin
				vneg_q  <= d2_q < var_q;
				vdiff_q <= (d2_q < var_q) ? (var_q - d2_q) : (d2_q - var_q);
				mneg_q  <= x2_q < msq_q;
				mdiff_q <= (x2_q < msq_q) ? (msq_q - x2_q) : (x2_q - msq_q);
			end
			copd_pkg::OP_VHI: acc_q <= {mul_q[47:0], 16'd0};
			copd_pkg::OP_MHI: acc_q <= {mul_q[47:0], 16'd0};
			copd_pkg::OP_INIT: begin
				rms_q <= ax_q[31] ? 31'h7FFF_FFFF : ax_q[30:0];
				dev_q <= ax_q[31] ? 31'h7FFF_FFFF : ax_q[30:0];
			end
			copd_pkg::OP_DEV: dev_q <= sq_sat;
			copd_pkg::OP_RMS: rms_q <= sq_sat;
			copd_pkg::OP_GAIN: gain_q <= (g_hi < cfg.gain_min) ? cfg.gain_min : g_hi;
			copd_pkg::OP_PROP: begin
				pmag_q <= p_shift[31:0];
				prop_q <= xneg_q ? -$signed(p_shift[31:0]) : $signed(p_shift[31:0]);
			end
			copd_pkg::OP_TRIM: begin
				step_q <= 1'b0;
				trim_q <= tclamp[31:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.publish) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			ostep_q   <= step_q;
			oamount_q <= step_q ? off_q : '0;
			otrim_q   <= step_q ? '0 : trim_q;
			omean_q   <= step_q ? '0 : mean_q;
			orms_q    <= step_q ? '0 : rms_q;
			odev_q    <= step_q ? '0 : dev_q;
			oprop_q   <= step_q ? '0 : prop_q;
			ointeg_q  <= step_q ? '0 : integ_q;
		end
	end

	assign sts.step     = (off_q > lim_p) || (off_q < lim_n);
	assign sts.init     = (msq_q == 64'd0);
	assign sts.sq_done  = sq_done;
	assign sts.sq_busy  = sq_busy;
	assign sts.out_free = !ovalid_q || out_ready;

	assign out_valid     = ovalid_q;
	assign step_clock    = ostep_q;
	assign step_amount   = oamount_q;
	assign trim_word     = otrim_q;
	assign mean_offset   = omean_q;
	assign rms_offset    = orms_q;
	assign dev_offset    = odev_q;
	assign prop_term     = oprop_q;
	assign integral_term = ointeg_q;

endmodule

### rtl/core/copd_ctrl.sv
// ----------------------------------------------------------------------------
// Clock offset PI discipline controller
// Sequences the datapath through one update per accepted word.
// ----------------------------------------------------------------------------
`include "clock_offset_pi_discipline_unit_defines.svh"

module copd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  copd_pkg::sts_t sts,
	output copd_pkg::cmd_t cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_CHECK = 5'd1;
	localparam logic [4:0] S_D2    = 5'd2;
	localparam logic [4:0] S_CD2   = 5'd3;
	localparam logic [4:0] S_DIF   = 5'd4;
	localparam logic [4:0] S_VH    = 5'd5;
	localparam logic [4:0] S_VL    = 5'd6;
	localparam logic [4:0] S_MH    = 5'd7;
	localparam logic [4:0] S_ML    = 5'd8;
	localparam logic [4:0] S_MN    = 5'd9;
	localparam logic [4:0] S_MNC   = 5'd10;
	localparam logic [4:0] S_WDEV  = 5'd11;
	localparam logic [4:0] S_WRMS  = 5'd12;
	localparam logic [4:0] S_INIT  = 5'd13;
	localparam logic [4:0] S_GN    = 5'd14;
	localparam logic [4:0] S_GC    = 5'd15;
	localparam logic [4:0] S_PR    = 5'd16;
	localparam logic [4:0] S_PC    = 5'd17;
	localparam logic [4:0] S_IN    = 5'd18;
	localparam logic [4:0] S_IC    = 5'd19;
	localparam logic [4:0] S_TR    = 5'd20;
	localparam logic [4:0] S_PUB   = 5'd21;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.op       = copd_pkg::OP_NONE;
		cmd.mul_sel  = copd_pkg::MS_X2;
		in_ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.step) begin
					cmd.op  = copd_pkg::OP_STEP;
					state_d = S_PUB;
				end else begin
					cmd.op      = copd_pkg::OP_PREP;
					cmd.mul_sel = copd_pkg::MS_X2;
					state_d     = S_D2;
				end
			end
			S_D2: begin
				cmd.mul_sel = copd_pkg::MS_D2;
				cmd.op      = copd_pkg::OP_CAP_X2;
				state_d     = sts.init ? S_INIT : S_CD2;
			end
			S_CD2: begin
				cmd.op  = copd_pkg::OP_CAP_D2;
				state_d = S_DIF;
			end
			S_DIF: begin
				cmd.op  = copd_pkg::OP_DIFF;
				state_d = S_VH;
			end
			S_VH: begin
				cmd.mul_sel = copd_pkg::MS_VHI;
				state_d     = S_VL;
			end
			S_VL: begin
				cmd.mul_sel = copd_pkg::MS_VLO;
				cmd.op      = copd_pkg::OP_VHI;
				state_d     = S_MH;
			end
			S_MH: begin
				cmd.mul_sel = copd_pkg::MS_MHI;
				cmd.op      = copd_pkg::OP_VLO;
				state_d     = S_ML;
			end
			S_ML: begin
				cmd.mul_sel = copd_pkg::MS_MLO;
				cmd.op      = copd_pkg::OP_MHI;
				state_d     = S_MN;
			end
			S_MN: begin
				cmd.mul_sel = copd_pkg::MS_MEAN;
				cmd.op      = copd_pkg::OP_MLO;
				state_d     = S_MNC;
			end
			S_MNC: begin
				cmd.op       = copd_pkg::OP_MEAN;
				cmd.sq_start = 1'b1;
				cmd.sq_sel   = 1'b0;
				state_d      = S_WDEV;
			end
			S_WDEV: begin
				if (sts.sq_done) begin
					cmd.op       = copd_pkg::OP_DEV;
					cmd.sq_start = 1'b1;
					cmd.sq_sel   = 1'b1;
					state_d      = S_WRMS;
				end
			end
			S_WRMS: begin
				if (sts.sq_done) begin
					cmd.op  = copd_pkg::OP_RMS;
					state_d = S_GN;
				end
			end
			S_INIT: begin
				cmd.op  = copd_pkg::OP_INIT;
				state_d = S_GN;
			end
			S_GN: begin
				cmd.mul_sel = copd_pkg::MS_GAIN;
				state_d     = S_GC;
			end
			S_GC: begin
				cmd.op  = copd_pkg::OP_GAIN;
				state_d = S_PR;
			end
			S_PR: begin
				cmd.mul_sel = copd_pkg::MS_PROP;
				state_d     = S_PC;
			end
			S_PC: begin
				cmd.op  = copd_pkg::OP_PROP;
				state_d = S_IN;
			end
			S_IN: begin
				cmd.mul_sel = copd_pkg::MS_INT;
				state_d     = S_IC;
			end
			S_IC: begin
				cmd.op  = copd_pkg::OP_INT;
				state_d = S_TR;
			end
			S_TR: begin
				cmd.op  = copd_pkg::OP_TRIM;
				state_d = S_PUB;
			end
			S_PUB: begin
				// hold until the output word slot frees up
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`COPD_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_q != S_IDLE)
	`COPD_ASSERT_IMP(a_publish_slot_free, cmd.publish, sts.out_free)
	`COPD_ASSERT_IMP(a_idle_root_quiet, state_q == S_IDLE, !sts.sq_busy)
	`COPD_ASSERT_IMP(a_root_done_waited, sts.sq_done, state_q == S_WDEV || state_q == S_WRMS)

endmodule

### rtl/core/clock_offset_pi_discipline_unit.sv
// One offset word in, one result word out. A word whose offset exceeds the
// step limit is the quickest from acceptance to result, then the first
// tracking update after reset or a step; a regular tracking update is the
// slowest, set by the single shared 32x32 multiplier (ten products in turn)
// and the bit-serial square root, which runs once for each of the
// variance and mean-square roots. The next word is taken once the previous
// result sits in the output register, even while that word waits downstream.
// ----------------------------------------------------------------------------
// Clock offset PI discipline unit
// Adaptive-gain PI loop turning measured clock offsets into frequency trims.
// ----------------------------------------------------------------------------
module clock_offset_pi_discipline_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         poll_interval,
	input  logic signed [63:0] offset,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               step_clock,
	output logic signed [63:0] step_amount,
	output logic signed [31:0] trim_word,
	output logic signed [31:0] mean_offset,
	output logic [30:0]        rms_offset,
	output logic [30:0]        dev_offset,
	output logic signed [31:0] prop_term,
	output logic signed [31:0] integral_term
);

	copd_pkg::cfg_t cfg_q;
	copd_pkg::cmd_t cmd;
	copd_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_limit    <= 31'd4294967;
			cfg_q.stats_alpha   <= 16'd6554;
			cfg_q.gain_per_rms  <= 32'd1000000;
			cfg_q.gain_max      <= 16'd32768;
			cfg_q.gain_min      <= 16'd655;
			cfg_q.integral_rate <= 16'd655;
			cfg_q.trim_limit    <= 31'd42950;
		end else if (cfg_valid) begin
			case (cfg_index)
				copd_pkg::CFG_STEP_LIMIT:    cfg_q.step_limit    <= cfg_data[30:0];
				copd_pkg::CFG_STATS_ALPHA:   cfg_q.stats_alpha   <= cfg_data[15:0];
				copd_pkg::CFG_GAIN_PER_RMS:  cfg_q.gain_per_rms  <= cfg_data;
				copd_pkg::CFG_GAIN_MAX:      cfg_q.gain_max      <= cfg_data[15:0];
				copd_pkg::CFG_GAIN_MIN:      cfg_q.gain_min      <= cfg_data[15:0];
				copd_pkg::CFG_INTEGRAL_RATE: cfg_q.integral_rate <= cfg_data[15:0];
				copd_pkg::CFG_TRIM_LIMIT:    cfg_q.trim_limit    <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	copd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	copd_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.sts           (sts),
		.poll_interval (poll_interval),
		.offset        (offset),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.step_clock    (step_clock),
		.step_amount   (step_amount),
		.trim_word     (trim_word),
		.mean_offset   (mean_offset),
		.rms_offset    (rms_offset),
		.dev_offset    (dev_offset),
		.prop_term     (prop_term),
		.integral_term (integral_term)
	);

endmodule

### dv/clock_offset_pi_discipline_unit_test.sv
// ----------------------------------------------------------------------------
// Clock offset PI discipline unit testbench
// Drives offset words through the valid/ready channels under several idle
// patterns and register settings, predicts every result with a bit-accurate
// model of the loop, and compares each result word, all fields at once, with the prediction.
// ----------------------------------------------------------------------------
module clock_offset_pi_discipline_unit_test;

	typedef struct packed {
		logic        step;
		logic [63:0] amount;
		logic [31:0] trim;
		logic [31:0] mean;
		logic [30:0] rms;
		logic [30:0] dev;
		logic [31:0] prop;
		logic [31:0] integ;
	} trim_result_t;

	class trim_scoreboard;
		// loop settings
		logic [30:0] step_limit;
		logic [15:0] alpha;
		logic [31:0] gain_per_rms;
		logic [15:0] gain_max, gain_min, integral_rate;
		logic [30:0] trim_limit;
		// loop state
		logic signed [31:0] mean_q;
		logic [63:0] variance_q, mean_square_q;
		logic signed [31:0] integral_q;
		trim_result_t pending[$];
		int errors, checked, steps;

		function void init_state();
			step_limit = 31'd4294967; alpha = 16'd6554; gain_per_rms = 32'd1000000;
			gain_max = 16'd32768; gain_min = 16'd655; integral_rate = 16'd655;
			trim_limit = 31'd42950;
			mean_q = 0; variance_q = 0; mean_square_q = 0; integral_q = 0;
			pending.delete(); errors = 0; checked = 0; steps = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				copd_pkg::CFG_STEP_LIMIT:    step_limit = val[30:0];
				copd_pkg::CFG_STATS_ALPHA:   alpha = val[15:0];
				copd_pkg::CFG_GAIN_PER_RMS:  gain_per_rms = val;
				copd_pkg::CFG_GAIN_MAX:      gain_max = val[15:0];
				copd_pkg::CFG_GAIN_MIN:      gain_min = val[15:0];
				copd_pkg::CFG_INTEGRAL_RATE: integral_rate = val[15:0];
				copd_pkg::CFG_TRIM_LIMIT:    trim_limit = val[30:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] weigh(logic [63:0] x, logic [15:0] a);
			logic [127:0] p;
			p = {64'd0, x} * {112'd0, a};
			return p[79:16];
		endfunction

		function logic [63:0] blend(logic [63:0] s, logic [63:0] v);
			if (v >= s)
				return s + weigh(v - s, alpha);
			return s - weigh(s - v, alpha);
		endfunction

		function logic [31:0] root64(logic [63:0] v);
			logic [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r[31:0];
		endfunction

		function longint clamp_sym(longint v, logic [30:0] lim);
			longint l;
			l = longint'({33'd0, lim});
			if (v > l) return l;
			if (v < -l) return -l;
			return v;
		endfunction

		function void note_offset(logic [4:0] interval, logic signed [63:0] off);
			trim_result_t r;
			longint lim, x, d, prop, integ, trim;
			logic [63:0] ax, x2, ad, d2, rms, dev, gain, pm;
			logic [127:0] wide;
			int sh;
			r = '0;
			lim = longint'({33'd0, step_limit});
			if (off > lim || off < -lim) begin
				mean_square_q = 0;
				r.step = 1'b1;
				r.amount = off;
				steps++;
				pending.push_back(r);
				return;
			end
			x = longint'($signed(off[31:0]));
			ax = (x < 0) ? -x : x;
			x2 = ax * ax;
			if (mean_square_q == 0) begin
				mean_q = x;
				variance_q = x2;
				mean_square_q = x2;
				rms = ax;
				dev = ax;
			end else begin
				d = x - longint'(mean_q);
				ad = (d < 0) ? -d : d;
				d2 = (ad > 64'hFFFF_FFFF) ? '1 : ad * ad;
				variance_q = blend(variance_q, d2);
				mean_square_q = blend(mean_square_q, x2);
				pm = weigh(ad, alpha);
				mean_q = longint'(mean_q) + ((d < 0) ? -longint'(pm) : longint'(pm));
				dev = root64(variance_q);
				rms = root64(mean_square_q);
			end
			if (rms > 64'h7FFF_FFFF) rms = 64'h7FFF_FFFF;
			if (dev > 64'h7FFF_FFFF) dev = 64'h7FFF_FFFF;
			wide = {64'd0, rms} * {96'd0, gain_per_rms};
			gain = wide[79:16];
			if (gain > gain_max) gain = gain_max;
			if (gain < gain_min) gain = gain_min;
			sh = 16 + ((interval > copd_pkg::MAX_INTERVAL) ? copd_pkg::MAX_INTERVAL : interval);
			pm = (ax * gain) >> sh;
			prop = (x < 0) ? -longint'(pm) : longint'(pm);
			pm = weigh((prop < 0) ? -prop : prop, integral_rate);
			integ = longint'(integral_q) + ((prop < 0) ? -longint'(pm) : longint'(pm));
			integ = clamp_sym(integ, trim_limit);
			integral_q = integ;
			trim = clamp_sym(prop + integ, trim_limit);
			r.trim = trim[31:0];
			r.mean = mean_q;
			r.rms = rms[30:0];
			r.dev = dev[30:0];
			r.prop = prop[31:0];
			r.integ = integ[31:0];
			pending.push_back(r);
		endfunction

		function void check_result(trim_result_t got);
			trim_result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word");
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got != e) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch #%0d: exp step=%b amt=%h trim=%h mean=%h rms=%h ",
						"dev=%h prop=%h int=%h / got step=%b amt=%h trim=%h mean=%h ",
						"rms=%h dev=%h prop=%h int=%h"}, checked,
						e.step, e.amount, e.trim, e.mean, e.rms, e.dev, e.prop, e.integ,
						got.step, got.amount, got.trim, got.mean, got.rms, got.dev,
						got.prop, got.integ);
			end
		endfunction
	endclass

	logic clk = 1'b0, arst_n = 1'b0;
	logic cfg_valid = 1'b0, in_valid = 1'b0, out_ready = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic [4:0] poll_interval = '0;
	logic signed [63:0] offset = '0;
	logic cfg_ready, in_ready, out_valid, step_clock;
	logic signed [63:0] step_amount;
	logic signed [31:0] trim_word, mean_offset, prop_term, integral_term;
	logic [30:0] rms_offset, dev_offset;

	trim_scoreboard sb = new();
	int send_idle = 0, recv_stall = 0;
	longint cycles = 0;
	int cfg_writes = 0;

	always #5 clk = ~clk;

	clock_offset_pi_discipline_unit dut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3_000_000) begin
			$display("clock_offset_pi_discipline_unit_test: errors");
			$finish;
		end
	end

	// receiver: check accepted words, stall at random
	always @(posedge clk) begin
		trim_result_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.step = step_clock; got.amount = step_amount; got.trim = trim_word;
				got.mean = mean_offset; got.rms = rms_offset; got.dev = dev_offset;
				got.prop = prop_term; got.integ = integral_term;
				sb.check_result(got);
			end
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_offset(logic [4:0] iv, logic signed [63:0] off);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		in_valid <= 1'b1; poll_interval <= iv; offset <= off;
		do @(posedge clk); while (!in_ready);
		sb.note_offset(iv, off);
		in_valid <= 1'b0;
		// the block is not ready again in the cycle after an accept
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic signed [63:0] tracking_offset(int spread);
		logic signed [63:0] v;
		v = $signed({32'd0, $urandom}) % (64'sd1 <<< spread);
		return v;
	endfunction

	task automatic random_batch(int n);
		logic signed [63:0] off;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: off = {$urandom, $urandom};
				1: off = {{32{1'b0}}, $urandom};
				2: off = {{32{1'b1}}, $urandom};
				default: off = tracking_offset($urandom_range(2, 24));
			endcase
			send_offset($urandom_range(31), off);
		end
	endtask

	initial begin
		logic [2:0] r;
		sb.init_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: init, extremes, steps, interval clamp
		send_offset(5'd0, 64'sd1000);
		send_offset(5'd0, -64'sd1000);
		send_offset(5'd31, 64'sd0);
		send_offset(5'd16, 64'sd4294967);
		send_offset(5'd17, -64'sd4294967);
		send_offset(5'd3, 64'sd4294968);
		send_offset(5'd3, 64'sh7FFF_FFFF_FFFF_FFFF);
		send_offset(5'd3, 64'sh8000_0000_0000_0000);
		send_offset(5'd1, -64'sd5);
		send_offset(5'd2, 64'sd0);
		send_offset(5'd8, 64'sd7);
		drain();
		write_reg(copd_pkg::CFG_STEP_LIMIT, 32'hFFFF_FFFF);
		write_reg(copd_pkg::CFG_GAIN_MIN, 32'd65535);
		write_reg(copd_pkg::CFG_GAIN_MAX, 32'd0);
		write_reg(copd_pkg::CFG_TRIM_LIMIT, 32'h7FFF_FFFF);
		write_reg(copd_pkg::CFG_INTEGRAL_RATE, 32'd65535);
		write_reg(copd_pkg::CFG_GAIN_PER_RMS, 32'hFFFF_FFFF);
		write_reg(copd_pkg::CFG_STATS_ALPHA, 32'd0);
		send_offset(5'd0, 64'sh0000_0000_8000_0000);
		send_offset(5'd0, 64'sh0000_0000_7FFF_FFFF);
		send_offset(5'd0, 64'sh1234_5678_8000_0001);
		send_offset(5'd31, 64'sh0000_0001_0000_0000);
		send_offset(5'd0, -64'sd1);
		drain();
		write_reg(copd_pkg::CFG_STATS_ALPHA, 32'd65535);
		write_reg(copd_pkg::CFG_STEP_LIMIT, 32'd0);
		send_offset(5'd0, 64'sd0);
		send_offset(5'd0, 64'sd1);
		send_offset(5'd0, 64'sd0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			send_idle = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 12 : 54) : 0;
			recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 12 : 54) : 0;
			// new setting each phase, extremes now and then
			r = 3'($urandom_range(6));
			if (ph == 0) begin
				write_reg(copd_pkg::CFG_STEP_LIMIT, 32'h7FFF_FFFF);
				write_reg(copd_pkg::CFG_GAIN_PER_RMS, 32'd1);
				write_reg(copd_pkg::CFG_GAIN_MAX, 32'd65535);
				write_reg(copd_pkg::CFG_GAIN_MIN, 32'd0);
				write_reg(copd_pkg::CFG_STATS_ALPHA, 32'd1);
				write_reg(copd_pkg::CFG_INTEGRAL_RATE, 32'd0);
				write_reg(copd_pkg::CFG_TRIM_LIMIT, 32'd0);
			end else if (ph == 1) begin
				write_reg(copd_pkg::CFG_STEP_LIMIT, 32'd4294967);
				write_reg(copd_pkg::CFG_STATS_ALPHA, 32'd6554);
				write_reg(copd_pkg::CFG_GAIN_PER_RMS, 32'd1000000);
				write_reg(copd_pkg::CFG_GAIN_MAX, 32'd32768);
				write_reg(copd_pkg::CFG_GAIN_MIN, 32'd655);
				write_reg(copd_pkg::CFG_INTEGRAL_RATE, 32'd655);
				write_reg(copd_pkg::CFG_TRIM_LIMIT, 32'd42950);
			end else begin
				write_reg(r, $urandom);
				write_reg(copd_pkg::CFG_STEP_LIMIT, $urandom_range(1 << 26, 0));
			end
			random_batch(95);
			drain();
		end
		send_idle = 0;
		recv_stall = 0;
		$display("covered: %0d result words (%0d clock steps), %0d register writes",
			sb.checked, sb.steps, cfg_writes);
		$display("idle patterns none/sender/receiver/both, several register settings");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("clock_offset_pi_discipline_unit_test: clean");
		else
			$display("clock_offset_pi_discipline_unit_test: errors");
		$finish;
	end
endmodule

### clock_offset_pi_discipline_unit.f
+incdir+rtl/core
rtl/core/copd_pkg.sv
rtl/core/copd_sqrt.sv
rtl/core/copd_dpath.sv
rtl/core/copd_ctrl.sv
rtl/core/clock_offset_pi_discipline_unit.sv
dv/clock_offset_pi_discipline_unit_test.sv
